// ===== hdl/bmpe_pkg.sv =====
// shared types and constants for the bmp stream pixel encoder
package bmpe_pkg;

  localparam int COMP_W   = 24;                  // signed q8.16 colour component
  localparam int BYTE_W   = 8;
  localparam int CFG_W    = 13;                  // width and height registers
  localparam int CFG_IDX_W = 1;
  localparam int DEN_W    = 25;                  // divisor, holds one at FRAC_BITS = 24
  localparam int NUM_W    = COMP_W - 1 + BYTE_W; // 255 * positive component
  localparam int SH_W     = DEN_W + BYTE_W - 1;  // divisor aligned to top quotient bit
  localparam int HDR_LEN  = 54;
  localparam int HDR_IDX_W = 6;

  localparam logic [BYTE_W-1:0] HDR_MAGIC_0 = 8'h42; // 'B'
  localparam logic [BYTE_W-1:0] HDR_MAGIC_1 = 8'h4D; // 'M'
  localparam logic [BYTE_W-1:0] HDR_OFFSET  = 8'd54;
  localparam logic [BYTE_W-1:0] DIB_SIZE    = 8'd40;
  localparam logic [BYTE_W-1:0] PLANES      = 8'd1;
  localparam logic [BYTE_W-1:0] BITS_PER_PX = 8'd24;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIZE,
    ST_HDR,
    ST_DSTART,
    ST_DWAIT,
    ST_DEMIT,
    ST_PAD
  } state_t;

  typedef enum logic [1:0] {
    COMP_BLUE,
    COMP_GREEN,
    COMP_RED
  } comp_t;

  typedef struct packed {
    logic                     start;
    logic signed [COMP_W-1:0] comp;
    logic signed [COMP_W-1:0] maxv;
  } div_cmd_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [BYTE_W-1:0] quot;
  } div_stat_t;

  typedef struct packed {
    logic start;
    logic step;
  } hdr_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } hdr_stat_t;

endpackage

// ===== hdl/bmpe_div.sv =====
// bit-serial restoring divider giving one colour byte, one quotient bit per cycle
module bmpe_div import bmpe_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  div_cmd_t  cmd,
  output div_stat_t stat
);

  localparam logic [DEN_W-1:0] ONE = DEN_W'(1) << FRAC_BITS;
  localparam int CNT_W = $clog2(BYTE_W);

  logic              c_pos;
  logic              m_gt;
  logic [NUM_W-1:0]  num0;
  logic [DEN_W-1:0]  den0;
  logic [SH_W-1:0]   diff;
  logic              ge;

  logic [NUM_W-1:0]  rem_r;
  logic [SH_W-1:0]   dsh_r;
  logic [BYTE_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  // quotient stays below 256 because the component never exceeds the divisor
  always_comb begin
    c_pos = !cmd.comp[COMP_W-1] && (cmd.comp != '0);
    m_gt  = !cmd.maxv[COMP_W-1] && (DEN_W'(cmd.maxv[COMP_W-2:0]) > ONE);
    num0  = c_pos ? ({cmd.comp[COMP_W-2:0], {BYTE_W{1'b0}}}
                     - NUM_W'(cmd.comp[COMP_W-2:0])) : '0;
    den0  = m_gt ? DEN_W'(cmd.maxv[COMP_W-2:0]) : ONE;
    ge    = SH_W'(rem_r) >= dsh_r;
    diff  = SH_W'(rem_r) - dsh_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (cmd.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BYTE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= num0;
      dsh_r <= SH_W'(den0) << (BYTE_W - 1);
      q_r   <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[BYTE_W-2:0], ge};
      dsh_r <= dsh_r >> 1;
      if (ge) begin
        rem_r <= diff[NUM_W-1:0];
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.quot = q_r;

endmodule

// ===== hdl/bmpe_hdr.sv =====
// file header generator: size product and byte selection by offset
module bmpe_hdr import bmpe_pkg::*; #(
  parameter int DW = 13
) (
  input  logic          clk,
  input  logic          rst_n,
  input  hdr_cmd_t      cmd,
  input  logic [DW-1:0] width,
  input  logic [DW-1:0] height,
  output hdr_stat_t     stat
);

  localparam int RBW = DW + 2;
  localparam int PW  = RBW + DW;
  localparam int OFS_FSIZE  = 2;
  localparam int OFS_OFFSET = 10;
  localparam int OFS_DIB    = 14;
  localparam int OFS_WIDTH  = 18;
  localparam int OFS_HEIGHT = 22;
  localparam int OFS_PLANES = 26;
  localparam int OFS_BPP    = 28;
  localparam int OFS_ISIZE  = 34;

  logic [HDR_IDX_W-1:0] idx_r;
  logic [DW-1:0]        w_r;
  logic [DW-1:0]        h_r;
  logic [31:0]          img_r;
  logic [RBW-1:0]       row_bytes;
  logic [PW-1:0]        img_prod;
  logic [31:0]          fsize;
  logic [31:0]          w32;
  logic [31:0]          h32;
  logic [BYTE_W-1:0]    data;

  function automatic logic [BYTE_W-1:0] le_byte(input logic [31:0] v, input logic [1:0] k);
    le_byte = v[k*BYTE_W +: BYTE_W];
  endfunction

  // rows are rounded up to whole 32-bit words
  assign row_bytes = ((RBW'(w_r) << 1) + RBW'(w_r) + RBW'(3)) & ~RBW'(3);
  assign img_prod  = PW'(row_bytes) * PW'(h_r);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w_r <= width;
      h_r <= height;
    end
    img_r <= 32'(img_prod);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.start) begin
      idx_r <= '0;
    end else if (cmd.step) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign fsize = 32'(HDR_OFFSET) + img_r;
  assign w32   = 32'(w_r);
  assign h32   = 32'(h_r);

  always_comb begin
    case (idx_r) inside
      HDR_IDX_W'(0): data = HDR_MAGIC_0;
      HDR_IDX_W'(1): data = HDR_MAGIC_1;
      [HDR_IDX_W'(OFS_FSIZE):HDR_IDX_W'(OFS_FSIZE + 3)]:
        data = le_byte(fsize, 2'(idx_r - HDR_IDX_W'(OFS_FSIZE)));
      HDR_IDX_W'(OFS_OFFSET): data = HDR_OFFSET;
      HDR_IDX_W'(OFS_DIB):    data = DIB_SIZE;
      [HDR_IDX_W'(OFS_WIDTH):HDR_IDX_W'(OFS_WIDTH + 3)]:
        data = le_byte(w32, 2'(idx_r - HDR_IDX_W'(OFS_WIDTH)));
      [HDR_IDX_W'(OFS_HEIGHT):HDR_IDX_W'(OFS_HEIGHT + 3)]:
        data = le_byte(h32, 2'(idx_r - HDR_IDX_W'(OFS_HEIGHT)));
      HDR_IDX_W'(OFS_PLANES): data = PLANES;
      HDR_IDX_W'(OFS_BPP):    data = BITS_PER_PX;
      [HDR_IDX_W'(OFS_ISIZE):HDR_IDX_W'(OFS_ISIZE + 3)]:
        data = le_byte(img_r, 2'(idx_r - HDR_IDX_W'(OFS_ISIZE)));
      default: data = '0;
    endcase
  end

  assign stat.data = data;
  assign stat.last = (idx_r == HDR_IDX_W'(HDR_LEN - 1));

endmodule

// ===== hdl/bmp_stream_pixel_encoder_top.sv =====
// top level: streams a 24-bit bmp file, one pixel word in, one file byte out
//
// channel  dir  handshake               payload
// in_      in   in_tvalid/in_tready     in_tdata = red, green, blue (q8.16, signed)
// out_     out  out_tvalid/out_tready   out_tdata byte, out_tlast, out_tuser = frame end
// cfg_     in   cfg_valid/cfg_ready     cfg_index, cfg_data (width, height)
//
// one pixel word at a time, padded at a row end; its colour bytes come from
// the 8-step bit-serial divider shared by the blue, green and red bytes
// the first word of a frame first passes the size product step, then the 54 header bytes
// the output register holds a byte while out_tready is low and the sequencer waits
// rst_n is synchronous, active low; width and height reset to 1, counters to zero
// cfg_ready is always high; writes are expected only while in_tready is high
module bmp_stream_pixel_encoder_top import bmpe_pkg::*; #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [3*COMP_W-1:0]  in_tdata,   // red [23:0], green [47:24], blue [71:48]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [BYTE_W-1:0]    out_tdata,  // out_byte [7:0]
  output logic                 out_tlast,
  output logic                 out_tuser,  // frame_end [0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int DW = $clog2(MAX_DIM + 1);

  // configuration
  logic [CFG_W-1:0] width_r;
  logic [CFG_W-1:0] height_r;
  logic [31:0]      w_full;
  logic [31:0]      h_full;
  logic [DW-1:0]    w_eff;
  logic [DW-1:0]    h_eff;
  logic [1:0]       pad_len;

  // sequencer state
  state_t           state_r, state_nxt;
  comp_t            comp_sel_r, comp_sel_nxt;
  logic [DW-1:0]    col_r, col_nxt;
  logic [DW-1:0]    row_r, row_nxt;
  logic             hdr_sent_r, hdr_sent_nxt;
  logic             frame_end_r, frame_end_nxt;
  logic [1:0]       pad_cnt_r, pad_cnt_nxt;

  // pixel words
  logic signed [COMP_W-1:0] red_r, green_r, blue_r;
  logic signed [COMP_W-1:0] max_c;

  // output register
  logic              out_tvalid_r;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_user_r, out_user_nxt;
  logic              out_load;
  logic              slot_free;

  logic      in_acc;
  logic      in_tready_c;
  logic      row_end;
  logic      frame_last;
  div_cmd_t  div_cmd;
  div_stat_t div_stat;
  hdr_cmd_t  hdr_cmd;
  hdr_stat_t hdr_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= CFG_W'(1);
      height_r <= CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
      endcase
    end
  end

  // zero acts as one, anything above the limit as the limit
  always_comb begin
    w_full = 32'(width_r);
    if (width_r == '0) begin
      w_full = 32'd1;
    end else if (w_full > 32'(MAX_DIM)) begin
      w_full = 32'(MAX_DIM);
    end
    h_full = 32'(height_r);
    if (height_r == '0) begin
      h_full = 32'd1;
    end else if (h_full > 32'(MAX_DIM)) begin
      h_full = 32'(MAX_DIM);
    end
  end

  assign w_eff = w_full[DW-1:0];
  assign h_eff = h_full[DW-1:0];
  // padding to a word boundary is width mod 4 for three bytes a pixel
  assign pad_len = w_full[1:0];

  assign row_end    = ((DW+1)'(col_r) + 1'b1) >= (DW+1)'(w_eff);
  assign frame_last = ((DW+1)'(row_r) + 1'b1) >= (DW+1)'(h_eff);

  assign in_acc    = in_tvalid && in_tready_c;
  assign in_tready = in_tready_c;
  assign slot_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      red_r   <= in_tdata[COMP_W-1:0];
      green_r <= in_tdata[2*COMP_W-1:COMP_W];
      blue_r  <= in_tdata[3*COMP_W-1:2*COMP_W];
    end
  end

  always_comb begin
    max_c = red_r;
    if (green_r > max_c) begin
      max_c = green_r;
    end
    if (blue_r > max_c) begin
      max_c = blue_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = hdr_sent_r ? ST_DSTART : ST_SIZE;
        end
      end
      ST_SIZE:   state_nxt = ST_HDR;
      ST_HDR: begin
        if (slot_free && hdr_stat.last) begin
          state_nxt = ST_DSTART;
        end
      end
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT: begin
        if (div_stat.done) begin
          state_nxt = ST_DEMIT;
        end
      end
      ST_DEMIT: begin
        if (slot_free) begin
          if (comp_sel_r == COMP_RED) begin
            state_nxt = (row_end && pad_len != 2'd0) ? ST_PAD : ST_IDLE;
          end else begin
            state_nxt = ST_DSTART;
          end
        end
      end
      ST_PAD: begin
        if (slot_free && pad_cnt_r == pad_len - 2'd1) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_tready_c   = 1'b0;
    out_load      = 1'b0;
    out_data_nxt  = '0;
    out_last_nxt  = 1'b0;
    out_user_nxt  = 1'b0;
    hdr_cmd       = '0;
    div_cmd.start = 1'b0;
    div_cmd.maxv  = max_c;
    comp_sel_nxt  = comp_sel_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    hdr_sent_nxt  = hdr_sent_r;
    frame_end_nxt = frame_end_r;
    pad_cnt_nxt   = pad_cnt_r;

    case (comp_sel_r)
      COMP_BLUE:  div_cmd.comp = blue_r;
      COMP_GREEN: div_cmd.comp = green_r;
      default:    div_cmd.comp = red_r;
    endcase

    unique case (state_r)
      ST_IDLE: begin
        in_tready_c = 1'b1;
        // ready is always high here, so valid alone marks the accepting edge
        if (in_tvalid) begin
          hdr_cmd.start = !hdr_sent_r;
          comp_sel_nxt  = COMP_BLUE;
        end
      end
      ST_SIZE: begin
      end
      ST_HDR: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = hdr_stat.data;
          hdr_cmd.step = 1'b1;
          if (hdr_stat.last) begin
            hdr_sent_nxt = 1'b1;
          end
        end
      end
      ST_DSTART: begin
        div_cmd.start = 1'b1;
      end
      ST_DWAIT: begin
      end
      ST_DEMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_data_nxt = div_stat.quot;
          if (comp_sel_r == COMP_RED) begin
            // end of pixel: padding, if any, carries the last flags
            out_last_nxt  = !(row_end && pad_len != 2'd0);
            out_user_nxt  = row_end && pad_len == 2'd0 && frame_last;
            frame_end_nxt = frame_last;
            pad_cnt_nxt   = 2'd0;
            if (row_end) begin
              col_nxt = '0;
              if (frame_last) begin
                row_nxt      = '0;
                hdr_sent_nxt = 1'b0;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt = col_r + 1'b1;
            end
          end else if (comp_sel_r == COMP_BLUE) begin
            comp_sel_nxt = COMP_GREEN;
          end else begin
            comp_sel_nxt = COMP_RED;
          end
        end
      end
      ST_PAD: begin
        if (slot_free) begin
          out_load    = 1'b1;
          pad_cnt_nxt = pad_cnt_r + 2'd1;
          if (pad_cnt_r == pad_len - 2'd1) begin
            out_last_nxt = 1'b1;
            out_user_nxt = frame_end_r;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      comp_sel_r  <= COMP_BLUE;
      col_r       <= '0;
      row_r       <= '0;
      hdr_sent_r  <= 1'b0;
      frame_end_r <= 1'b0;
      pad_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      comp_sel_r  <= comp_sel_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      hdr_sent_r  <= hdr_sent_nxt;
      frame_end_r <= frame_end_nxt;
      pad_cnt_r   <= pad_cnt_nxt;
    end
  end

  // output register, refilled in the cycle the held word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
      out_last_r <= out_last_nxt;
      out_user_r <= out_user_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  bmpe_hdr #(
    .DW (DW)
  ) u_hdr (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (hdr_cmd),
    .width  (w_eff),
    .height (h_eff),
    .stat   (hdr_stat)
  );

  bmpe_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (div_cmd),
    .stat  (div_stat)
  );

  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !div_stat.busy)
    else $error("divider busy while waiting for a pixel word");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == ST_DWAIT)
    else $error("divider finished outside the wait state");

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r && out_user_r |-> out_last_r)
    else $error("frame end flagged on a byte that is not a pixel's last");

  a_hdr_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(hdr_sent_r) && $past(rst_n) |-> $past(row_end && frame_last))
    else $error("header flag cleared before the frame completed");

endmodule
